>>> design/atint_pkg.sv
// Shared constants, codes and types of the antiperiodic table interpolator.
// No dependencies; imported by every design module but atint_ram, and by the checker.
`default_nettype none

package atint_pkg;

    localparam int GRID_POINTS  = 256;
    localparam int SITE_COUNT   = 4;
    localparam int FLAVOR_COUNT = 2;
    localparam int TIME_BITS    = 20;

    localparam int SITE_BITS    = 2;
    localparam int FLAVOR_BITS  = 1;
    localparam int DT_BITS      = TIME_BITS + 1;
    localparam int DATA_BITS    = 32;
    localparam int CMD_BITS     = 1;

    localparam int ROW_LEN      = GRID_POINTS + 1;
    localparam int ROW_COUNT    = FLAVOR_COUNT * SITE_COUNT * SITE_COUNT;
    localparam int ROW_BITS     = FLAVOR_BITS + 2 * SITE_BITS;
    localparam int TABLE_DEPTH  = ROW_COUNT * ROW_LEN;
    localparam int ADDR_BITS    = $clog2(TABLE_DEPTH);
    localparam int IDX_BITS     = $clog2(ROW_LEN);

    localparam int GRID_SHIFT   = $clog2(GRID_POINTS);
    localparam int FRAC_BITS    = (TIME_BITS > 30) ? 30 : TIME_BITS;
    localparam int LO_BITS      = TIME_BITS - GRID_SHIFT;
    localparam int DIFF_BITS    = DATA_BITS + 1;
    localparam int PROD_BITS    = DIFF_BITS + FRAC_BITS + 1;
    localparam int SUM_BITS     = PROD_BITS - FRAC_BITS;

    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;
    localparam int REG_BITS     = PADDR_BITS - 2;

    localparam logic [CMD_BITS-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_BITS-1:0] CMD_QUERY = 1'b1;

    localparam logic [REG_BITS-1:0] REG_ZERO_WINDOW = 1'b0;
    localparam logic [TIME_BITS-1:0] ZERO_WINDOW_RESET = TIME_BITS'(1);

    localparam logic signed [DATA_BITS-1:0] DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam logic signed [DATA_BITS-1:0] DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] addr0;
        logic [ADDR_BITS-1:0] addr1;
        logic [DATA_BITS-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic                 valid;
        logic                 kill;
        logic                 neg;
        logic [FRAC_BITS-1:0] frac;
    } side_t;

endpackage

`default_nettype wire

>>> design/atint_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; instanced twice by the top level for the two sample reads.
`default_nettype none

module atint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/atint_front.sv
// Front stages: input register, time decode, grid index and table address.
// Depends on atint_pkg; drives the table RAM ports and the sideband to stage 3.
`default_nettype none

module atint_front
    import atint_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [CMD_BITS-1:0]           command,
    input  wire logic signed [DT_BITS-1:0]     delta_time,
    input  wire logic [FLAVOR_BITS-1:0]        flavor_a,
    input  wire logic [FLAVOR_BITS-1:0]        flavor_b,
    input  wire logic [SITE_BITS-1:0]          site_a,
    input  wire logic [SITE_BITS-1:0]          site_b,
    input  wire logic [IDX_BITS-1:0]           time_index,
    input  wire logic signed [DATA_BITS-1:0]   entry_value,
    input  wire logic [TIME_BITS-1:0]          zero_window,
    input  wire logic                          adv_down,
    output mem_req_t                           mem_req,
    output side_t                              side
);

    logic                   s1_valid_reg;
    logic [CMD_BITS-1:0]    s1_cmd_reg;
    logic [DT_BITS-1:0]     s1_dt_reg;
    logic [FLAVOR_BITS-1:0] s1_fa_reg;
    logic [FLAVOR_BITS-1:0] s1_fb_reg;
    logic [SITE_BITS-1:0]   s1_sa_reg;
    logic [SITE_BITS-1:0]   s1_sb_reg;
    logic [IDX_BITS-1:0]    s1_ti_reg;
    logic [DATA_BITS-1:0]   s1_wval_reg;

    logic                   s2_valid_reg;
    logic                   s2_query_reg;
    logic                   s2_wr_ok_reg;
    logic                   s2_kill_reg;
    logic                   s2_neg_reg;
    logic [FRAC_BITS-1:0]   s2_frac_reg;
    logic [ADDR_BITS-1:0]   s2_base_reg;
    logic [IDX_BITS-1:0]    s2_idx0_reg;
    logic [IDX_BITS-1:0]    s2_idx1_reg;
    logic [DATA_BITS-1:0]   s2_wval_reg;

    logic                   adv1;
    logic                   adv2;
    logic [ROW_BITS-1:0]    row;
    logic [DT_BITS-1:0]     mag;
    logic                   zero;
    logic                   pos;
    logic [DT_BITS-1:0]     t;
    logic [IDX_BITS-1:0]    i0;
    logic [IDX_BITS-1:0]    i1;
    logic                   query;
    logic                   kill_next;
    logic                   neg_next;
    logic                   wr_ok_next;
    logic [FRAC_BITS-1:0]   frac_next;
    logic [ADDR_BITS-1:0]   base_next;
    logic [IDX_BITS-1:0]    idx0_next;
    logic [IDX_BITS-1:0]    idx1_next;

    assign adv2      = !s2_valid_reg || adv_down;
    assign adv1      = !s1_valid_reg || adv2;
    assign req_ready = adv1;

    always_comb
    begin
        row        = {s1_fa_reg, s1_sa_reg, s1_sb_reg};
        base_next  = ADDR_BITS'(row) * ADDR_BITS'(ROW_LEN);
        mag        = s1_dt_reg[DT_BITS-1] ? (~s1_dt_reg + DT_BITS'(1)) : s1_dt_reg;
        zero       = mag < DT_BITS'(zero_window);
        pos        = !s1_dt_reg[DT_BITS-1] && (s1_dt_reg != '0);
        if (zero)
        begin
            t = '0;
        end
        else if (pos)
        begin
            t = s1_dt_reg;
        end
        else
        begin
            t = s1_dt_reg + (DT_BITS'(1) << TIME_BITS);
        end
        i0         = IDX_BITS'(t >> LO_BITS);
        i1         = (zero || (i0 == IDX_BITS'(GRID_POINTS))) ? i0 : i0 + IDX_BITS'(1);
        frac_next  = FRAC_BITS'(t[LO_BITS-1:0]) << GRID_SHIFT;
        query      = (s1_cmd_reg == CMD_QUERY);
        kill_next  = (s1_fa_reg != s1_fb_reg);
        neg_next   = !zero && !pos;
        wr_ok_next = (s1_ti_reg <= IDX_BITS'(GRID_POINTS));
        idx0_next  = query ? i0 : s1_ti_reg;
        idx1_next  = query ? i1 : s1_ti_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= req_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && req_valid)
        begin
            s1_cmd_reg  <= command;
            s1_dt_reg   <= delta_time;
            s1_fa_reg   <= flavor_a;
            s1_fb_reg   <= flavor_b;
            s1_sa_reg   <= site_a;
            s1_sb_reg   <= site_b;
            s1_ti_reg   <= time_index;
            s1_wval_reg <= entry_value;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_query_reg <= query;
            s2_wr_ok_reg <= wr_ok_next;
            s2_kill_reg  <= kill_next;
            s2_neg_reg   <= neg_next;
            s2_frac_reg  <= frac_next;
            s2_base_reg  <= base_next;
            s2_idx0_reg  <= idx0_next;
            s2_idx1_reg  <= idx1_next;
            s2_wval_reg  <= s1_wval_reg;
        end
    end

    always_comb
    begin
        mem_req.we    = s2_valid_reg && !s2_query_reg && s2_wr_ok_reg && adv_down;
        mem_req.addr0 = s2_base_reg + ADDR_BITS'(s2_idx0_reg);
        mem_req.addr1 = s2_base_reg + ADDR_BITS'(s2_idx1_reg);
        mem_req.wdata = s2_wval_reg;
        side.valid    = s2_valid_reg && s2_query_reg;
        side.kill     = s2_kill_reg;
        side.neg      = s2_neg_reg;
        side.frac     = s2_frac_reg;
    end

endmodule

`default_nettype wire

>>> design/atint_back.sv
// Back stages: difference, fraction multiply, truncating add, negate or zero, and output register.
// Depends on atint_pkg; fed by the stage 3 sample registers of the top level.
`default_nettype none

module atint_back
    import atint_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  side_t                            side,
    input  wire logic signed [DATA_BITS-1:0] y0,
    input  wire logic signed [DATA_BITS-1:0] y1,
    output logic                             take,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output logic signed [DATA_BITS-1:0]      green_value
);

    logic                        s4_valid_reg;
    side_t                       s4_side_reg;
    logic signed [DATA_BITS-1:0] s4_y0_reg;
    logic signed [DIFF_BITS-1:0] s4_diff_reg;

    logic                        s5_valid_reg;
    side_t                       s5_side_reg;
    logic signed [DATA_BITS-1:0] s5_y0_reg;
    logic signed [PROD_BITS-1:0] s5_prod_reg;

    logic                        s6_valid_reg;
    side_t                       s6_side_reg;
    logic signed [DATA_BITS-1:0] s6_r_reg;

    logic                        out_valid_reg;
    logic signed [DATA_BITS-1:0] out_value_reg;

    logic                        adv4;
    logic                        adv5;
    logic                        adv6;
    logic                        adv_out;
    logic signed [DIFF_BITS-1:0] diff_next;
    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [SUM_BITS-1:0]  sum_next;
    logic signed [DATA_BITS-1:0] out_next;

    assign adv_out = !out_valid_reg || rsp_ready;
    assign adv6    = !s6_valid_reg || adv_out;
    assign adv5    = !s5_valid_reg || adv6;
    assign adv4    = !s4_valid_reg || adv5;
    assign take    = adv4;

    always_comb
    begin
        diff_next = DIFF_BITS'(y1) - DIFF_BITS'(y0);
        prod_next = PROD_BITS'(s4_diff_reg) * PROD_BITS'($signed({1'b0, s4_side_reg.frac}));
        sum_next  = SUM_BITS'(s5_y0_reg) + SUM_BITS'(s5_prod_reg >>> FRAC_BITS);
        if (s6_side_reg.kill)
        begin
            out_next = '0;
        end
        else if (s6_side_reg.neg)
        begin
            out_next = (s6_r_reg == DATA_MIN) ? DATA_MAX : -s6_r_reg;
        end
        else
        begin
            out_next = s6_r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv4)
            begin
                s4_valid_reg <= side.valid;
            end
            if (adv5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (adv6)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s6_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && side.valid)
        begin
            s4_side_reg <= side;
            s4_y0_reg   <= y0;
            s4_diff_reg <= diff_next;
        end
        if (adv5 && s4_valid_reg)
        begin
            s5_side_reg <= s4_side_reg;
            s5_y0_reg   <= s4_y0_reg;
            s5_prod_reg <= prod_next;
        end
        if (adv6 && s5_valid_reg)
        begin
            s6_side_reg <= s5_side_reg;
            s6_r_reg    <= DATA_BITS'(sum_next);
        end
        if (adv_out && s6_valid_reg)
        begin
            out_value_reg <= out_next;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign green_value = out_value_reg;

endmodule

`default_nettype wire

>>> design/antiperiodic_table_interpolator.sv
// Top level of the antiperiodic table interpolator: APB register, table RAMs, stage 3.
// Depends on atint_pkg, atint_ram, atint_front and atint_back.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one command per transfer:
//   a table write (command = write) or a query. Writes load one 32-bit entry
//   of the table, selected by flavor_a, site_a, site_b and time_index, and
//   give no response. Each query gives one response transfer on the
//   rsp_valid/rsp_ready channel carrying green_value.
//   Pipeline: a query passes the input, decode, RAM read, difference, product,
//   sum and output registers before it is shown on rsp_valid.
//   Throughput: one transfer per cycle while req_ready is high; the table is kept as two RAM copies
//   with one port each, so both neighboring samples are read in the same cycle.
//   Writes go to both copies in pipeline order, so a query sees every earlier write.
//   Stalls: rsp_ready low holds the response; stages behind it keep filling
//   empty slots and req_ready drops only once every stage is occupied.
//   Reset: pipeline emptied, zero_window returns to 1. Table contents are
//   undefined until written.
//   APB: zero_window at address 0, written on the access cycle; pready is tied high.
`default_nettype none

module antiperiodic_table_interpolator
    import atint_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [PADDR_BITS-1:0]       paddr,
    input  wire logic [PDATA_BITS-1:0]       pwdata,
    output logic      [PDATA_BITS-1:0]       prdata,
    output logic                             pready,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic [CMD_BITS-1:0]         command,
    input  wire logic signed [DT_BITS-1:0]   delta_time,
    input  wire logic [FLAVOR_BITS-1:0]      flavor_a,
    input  wire logic [FLAVOR_BITS-1:0]      flavor_b,
    input  wire logic [SITE_BITS-1:0]        site_a,
    input  wire logic [SITE_BITS-1:0]        site_b,
    input  wire logic [IDX_BITS-1:0]         time_index,
    input  wire logic signed [DATA_BITS-1:0] entry_value,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output logic signed [DATA_BITS-1:0]      green_value
);

    logic [TIME_BITS-1:0] zero_window_reg;
    logic [REG_BITS-1:0]  reg_index;
    logic                 cfg_write;

    mem_req_t             mem_req;
    side_t                side_next;
    side_t                s3_side_reg;
    logic                 adv3;
    logic                 take;
    logic [DATA_BITS-1:0] y0;
    logic [DATA_BITS-1:0] y1;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_index == REG_ZERO_WINDOW) ? PDATA_BITS'(zero_window_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_window_reg <= ZERO_WINDOW_RESET;
        end
        else if (cfg_write && (reg_index == REG_ZERO_WINDOW))
        begin
            zero_window_reg <= pwdata[TIME_BITS-1:0];
        end
    end

    atint_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .command     (command),
        .delta_time  (delta_time),
        .flavor_a    (flavor_a),
        .flavor_b    (flavor_b),
        .site_a      (site_a),
        .site_b      (site_b),
        .time_index  (time_index),
        .entry_value (entry_value),
        .zero_window (zero_window_reg),
        .adv_down    (adv3),
        .mem_req     (mem_req),
        .side        (side_next)
    );

    assign adv3 = !s3_side_reg.valid || take;

    atint_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_lo (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (adv3),
        .addr  (mem_req.addr0),
        .wdata (mem_req.wdata),
        .rdata (y0)
    );

    atint_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_hi (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (adv3),
        .addr  (mem_req.addr1),
        .wdata (mem_req.wdata),
        .rdata (y1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_side_reg <= '0;
        end
        else if (adv3)
        begin
            s3_side_reg <= side_next;
        end
    end

    atint_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .side        (s3_side_reg),
        .y0          ($signed(y0)),
        .y1          ($signed(y1)),
        .take        (take),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .green_value (green_value)
    );

endmodule

`default_nettype wire

>>> design/atint_checker.sv
// Port-level checker for the antiperiodic table interpolator, bound to the top level.
// Depends on atint_pkg and the port list of antiperiodic_table_interpolator.
`default_nettype none

module atint_checker
    import atint_pkg::*;
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        pready,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic [CMD_BITS-1:0]         command,
    input wire logic [FLAVOR_BITS-1:0]      flavor_a,
    input wire logic [FLAVOR_BITS-1:0]      flavor_b,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic signed [DATA_BITS-1:0] green_value
);

    logic query_xfer;

    assign query_xfer = req_valid && req_ready && (command == CMD_QUERY);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(green_value))
        else $error("response changed while stalled");

    a_req_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid || rsp_ready |-> req_ready)
        else $error("request refused while response side is free");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        query_xfer ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
        ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
        else $error("query response missing after six free cycles");

    a_flavor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        query_xfer && (flavor_a != flavor_b) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
        ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> green_value == '0)
        else $error("flavor mismatch gave a nonzero response");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind antiperiodic_table_interpolator atint_checker u_atint_checker (.*);

`default_nettype wire

>>> dv/tb_antiperiodic_table_interpolator.sv
// Testbench for the antiperiodic table interpolator: directed and random table writes and
// queries, checked against an in-bench predictor, plus zero_window register access over APB.
// Depends on atint_pkg and the antiperiodic_table_interpolator design.
`timescale 1ns / 100ps

module tb_antiperiodic_table_interpolator;
    import atint_pkg::*;

    localparam int PIPE_DRAIN  = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int DT_LIMIT    = (1 << TIME_BITS) - 1;
    localparam longint PERIOD  = longint'(1) << TIME_BITS;
    localparam logic [REG_BITS-1:0]  REG_UNUSED      = 1'b1;
    localparam logic [TIME_BITS-1:0] ZERO_WINDOW_MAX = '1;

    typedef struct {
        logic [CMD_BITS-1:0]         cmd;
        logic signed [DT_BITS-1:0]   dt;
        logic [FLAVOR_BITS-1:0]      fa;
        logic [FLAVOR_BITS-1:0]      fb;
        logic [SITE_BITS-1:0]        sa;
        logic [SITE_BITS-1:0]        sb;
        logic [IDX_BITS-1:0]         ti;
        logic signed [DATA_BITS-1:0] val;
    } table_req_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_BITS-1:0]       paddr;
    logic [PDATA_BITS-1:0]       pwdata;
    logic [PDATA_BITS-1:0]       prdata;
    logic                        pready;
    logic                        req_valid;
    logic                        req_ready;
    logic [CMD_BITS-1:0]         command;
    logic signed [DT_BITS-1:0]   delta_time;
    logic [FLAVOR_BITS-1:0]      flavor_a;
    logic [FLAVOR_BITS-1:0]      flavor_b;
    logic [SITE_BITS-1:0]        site_a;
    logic [SITE_BITS-1:0]        site_b;
    logic [IDX_BITS-1:0]         time_index;
    logic signed [DATA_BITS-1:0] entry_value;
    logic                        rsp_valid;
    logic                        rsp_ready = 1'b0;
    logic signed [DATA_BITS-1:0] green_value;

    logic signed [DATA_BITS-1:0] samples [TABLE_DEPTH];
    bit                          loaded  [TABLE_DEPTH];
    logic [TIME_BITS-1:0]        zero_win = ZERO_WINDOW_RESET;
    logic signed [DATA_BITS-1:0] green_due [$];
    logic signed [DATA_BITS-1:0] green_want;

    int mismatches = 0;
    int send_pct   = 0;
    int recv_pct   = 0;
    int hold_left  = 0;

    antiperiodic_table_interpolator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .command     (command),
        .delta_time  (delta_time),
        .flavor_a    (flavor_a),
        .flavor_b    (flavor_b),
        .site_a      (site_a),
        .site_b      (site_b),
        .time_index  (time_index),
        .entry_value (entry_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .green_value (green_value)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    function automatic int unsigned row_base(logic [FLAVOR_BITS-1:0] fl,
                                             logic [SITE_BITS-1:0] sa,
                                             logic [SITE_BITS-1:0] sb);
        return ((int'(fl) * SITE_COUNT + int'(sa)) * SITE_COUNT + int'(sb)) * ROW_LEN;
    endfunction

    // Find the two grid entries and the fraction that a query reads; 0 when flavors differ.
    function automatic bit locate(input table_req_t r, output int unsigned i0,
                                  output int unsigned i1, output longint frac,
                                  output bit negate);
        longint d;
        longint mag;
        longint t;
        longint u;
        d      = longint'(r.dt);
        i0     = 0;
        i1     = 0;
        frac   = 0;
        negate = 1'b0;
        if (r.fa != r.fb)
        begin
            return 1'b0;
        end
        mag = (d < 0) ? -d : d;
        if (mag < longint'(zero_win))
        begin
            return 1'b1;
        end
        negate = (d <= 0);
        t      = negate ? d + PERIOD : d;
        u      = t * GRID_POINTS;
        i0     = int'(u >> TIME_BITS);
        if (i0 > GRID_POINTS)
        begin
            i0 = GRID_POINTS;
        end
        i1   = (i0 + 1 > GRID_POINTS) ? GRID_POINTS : i0 + 1;
        frac = (u & (PERIOD - 1)) >> (TIME_BITS - FRAC_BITS);
        return 1'b1;
    endfunction

    function automatic logic signed [DATA_BITS-1:0] green_of(table_req_t r);
        int unsigned i0;
        int unsigned i1;
        int unsigned base;
        longint      frac;
        longint      y0;
        longint      y1;
        longint      v;
        bit          negate;
        if (!locate(r, i0, i1, frac, negate))
        begin
            return '0;
        end
        base = row_base(r.fa, r.sa, r.sb);
        y0   = samples[base + i0];
        y1   = samples[base + i1];
        v    = y0 + (((y1 - y0) * frac) >>> FRAC_BITS);
        if (negate)
        begin
            v = (v == longint'(DATA_MIN)) ? longint'(DATA_MAX) : -v;
        end
        return DATA_BITS'(v);
    endfunction

    function automatic void absorb(table_req_t r);
        int unsigned base;
        base = row_base(r.fa, r.sa, r.sb);
        if (r.cmd == CMD_WRITE)
        begin
            if (r.ti <= GRID_POINTS)
            begin
                samples[base + r.ti] = r.val;
                loaded[base + r.ti]  = 1'b1;
            end
        end
        else
        begin
            green_due.push_back(green_of(r));
        end
    endfunction

    function automatic logic signed [DATA_BITS-1:0] pick_value();
        case ($urandom_range(7))
            0:       return DATA_MIN;
            1:       return DATA_MAX;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_time();
        int v;
        case ($urandom_range(5))
            0:       v = int'(zero_win) - 1 + int'($urandom_range(2));
            1:       v = int'($urandom_range(GRID_POINTS)) << LO_BITS;
            2:       v = int'($urandom_range(8));
            default: v = int'($urandom_range(DT_LIMIT));
        endcase
        if ($urandom_range(1) == 1)
        begin
            v = -v;
        end
        if (v > DT_LIMIT)
        begin
            v = DT_LIMIT;
        end
        if (v < -DT_LIMIT)
        begin
            v = -DT_LIMIT;
        end
        return v;
    endfunction

    function automatic table_req_t make_write(logic [FLAVOR_BITS-1:0] fa,
                                              logic [SITE_BITS-1:0] sa,
                                              logic [SITE_BITS-1:0] sb,
                                              logic [IDX_BITS-1:0] ti,
                                              logic signed [DATA_BITS-1:0] val);
        table_req_t r;
        r.cmd = CMD_WRITE;
        r.dt  = DT_BITS'($urandom);
        r.fa  = fa;
        r.fb  = FLAVOR_BITS'($urandom);
        r.sa  = sa;
        r.sb  = sb;
        r.ti  = ti;
        r.val = val;
        return r;
    endfunction

    task automatic send_item(table_req_t r);
        while ($urandom_range(99) < send_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        command     <= r.cmd;
        delta_time  <= r.dt;
        flavor_a    <= r.fa;
        flavor_b    <= r.fb;
        site_a      <= r.sa;
        site_b      <= r.sb;
        time_index  <= r.ti;
        entry_value <= r.val;
        do
            @(posedge clk);
        while (!req_ready);
        absorb(r);
        @(negedge clk);
    endtask

    // Load any neighbor entry the query would read that was never written, then query.
    task automatic send_query(logic [FLAVOR_BITS-1:0] fa, logic [FLAVOR_BITS-1:0] fb,
                              logic [SITE_BITS-1:0] sa, logic [SITE_BITS-1:0] sb, int dt);
        table_req_t  q;
        int unsigned i0;
        int unsigned i1;
        int unsigned base;
        longint      frac;
        bit          negate;
        q.cmd = CMD_QUERY;
        q.dt  = DT_BITS'(dt);
        q.fa  = fa;
        q.fb  = fb;
        q.sa  = sa;
        q.sb  = sb;
        q.ti  = IDX_BITS'($urandom);
        q.val = $urandom;
        if (locate(q, i0, i1, frac, negate))
        begin
            base = row_base(fa, sa, sb);
            if (!loaded[base + i0])
            begin
                send_item(make_write(fa, sa, sb, IDX_BITS'(i0), pick_value()));
            end
            if (!loaded[base + i1])
            begin
                send_item(make_write(fa, sa, sb, IDX_BITS'(i1), pick_value()));
            end
        end
        send_item(q);
    endtask

    task automatic send_random_item(int write_pct);
        int                     roll;
        logic [FLAVOR_BITS-1:0] fa;
        logic [SITE_BITS-1:0]   sa;
        logic [SITE_BITS-1:0]   sb;
        roll = $urandom_range(99);
        fa   = FLAVOR_BITS'($urandom);
        sa   = ($urandom_range(3) == 0) ? SITE_BITS'($urandom) : SITE_BITS'($urandom_range(1));
        sb   = ($urandom_range(3) == 0) ? SITE_BITS'($urandom) : SITE_BITS'($urandom_range(1));
        if (roll < write_pct)
        begin
            send_item(make_write(fa, sa, sb,
                                 ($urandom_range(9) == 0) ? IDX_BITS'($urandom)
                                                          : IDX_BITS'($urandom_range(GRID_POINTS)),
                                 pick_value()));
        end
        else if (roll < write_pct + 5)
        begin
            send_query(fa, FLAVOR_BITS'($urandom), sa, sb, pick_time());
        end
        else
        begin
            send_query(fa, fa, sa, sb, pick_time());
        end
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (green_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic apb_access(logic wr, logic [REG_BITS-1:0] idx, logic [PDATA_BITS-1:0] wdata,
                              output logic [PDATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_zero_window();
        logic [PDATA_BITS-1:0] rd;
        apb_access(1'b0, REG_ZERO_WINDOW, '0, rd);
        if (rd !== PDATA_BITS'(zero_win))
        begin
            report_mismatch($sformatf("zero_window read: expected %0h, got %0h",
                                      PDATA_BITS'(zero_win), rd));
        end
    endtask

    task automatic set_zero_window(logic [TIME_BITS-1:0] val);
        logic [PDATA_BITS-1:0] rd;
        wait_idle();
        apb_access(1'b1, REG_ZERO_WINDOW, ($urandom & ~PDATA_BITS'(ZERO_WINDOW_MAX)) | val, rd);
        zero_win = val;
        check_zero_window();
    endtask

    task automatic test_zero_window_reg();
        logic [PDATA_BITS-1:0] rd;
        check_zero_window();
        apb_access(1'b1, REG_UNUSED, $urandom, rd);
        check_zero_window();
        set_zero_window(ZERO_WINDOW_MAX);
        set_zero_window(ZERO_WINDOW_RESET);
    endtask

    task automatic test_directed();
        send_pct = 0;
        recv_pct = 0;
        send_item(make_write(1'b0, 2'd1, 2'd2, 9'd0, DATA_MAX));
        send_item(make_write(1'b0, 2'd1, 2'd2, 9'd1, DATA_MIN));
        send_item(make_write(1'b0, 2'd1, 2'd2, 9'd255, DATA_MIN));
        send_item(make_write(1'b0, 2'd1, 2'd2, 9'd256, DATA_MIN));
        send_query(1'b0, 1'b0, 2'd1, 2'd2, 0);
        send_query(1'b0, 1'b0, 2'd1, 2'd2, 1 << (LO_BITS - 1));
        send_query(1'b0, 1'b0, 2'd1, 2'd2, 1);
        // negated -2^31 saturates
        send_query(1'b0, 1'b0, 2'd1, 2'd2, -1);
        send_query(1'b0, 1'b0, 2'd1, 2'd2, -DT_LIMIT);
        send_query(1'b0, 1'b0, 2'd1, 2'd2, DT_LIMIT);
        send_query(1'b0, 1'b1, 2'd1, 2'd2, DT_LIMIT);
        send_query(1'b1, 1'b0, 2'd1, 2'd2, -DT_LIMIT);
        // grid indexes above the top point are dropped
        send_item(make_write(1'b0, 2'd1, 2'd2, '1, $urandom));
        send_item(make_write(1'b0, 2'd1, 2'd2, 9'd257, $urandom));
        send_query(1'b0, 1'b0, 2'd1, 2'd2, -1);
        send_query(1'b0, 1'b0, 2'd1, 2'd3, 0);
        send_query(1'b1, 1'b1, 2'd3, 2'd3, 1 << (TIME_BITS - 1));
        send_query(1'b1, 1'b1, 2'd3, 2'd3, -(1 << (TIME_BITS - 1)));
        // zero time with no window reads the top grid point
        set_zero_window('0);
        send_query(1'b0, 1'b0, 2'd1, 2'd2, 0);
        send_query(1'b1, 1'b1, 2'd3, 2'd3, 0);
        set_zero_window(ZERO_WINDOW_MAX);
        send_query(1'b0, 1'b0, 2'd1, 2'd2, DT_LIMIT - 1);
        send_query(1'b0, 1'b0, 2'd1, 2'd2, -DT_LIMIT);
        set_zero_window(ZERO_WINDOW_RESET);
    endtask

    task automatic test_random_traffic(int count, int sp, int rp, logic [TIME_BITS-1:0] zw);
        set_zero_window(zw);
        send_pct = sp;
        recv_pct = rp;
        repeat (count) send_random_item(25);
    endtask

    task automatic test_backpressure();
        send_pct = 0;
        recv_pct = 9;
        wait_idle();
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        repeat (80) send_random_item(10);
        wait_idle();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (green_due.size() == 0)
            begin
                report_mismatch($sformatf("green_value %0d with no query pending", green_value));
            end
            else
            begin
                green_want = green_due.pop_front();
                if (green_value !== green_want)
                begin
                    report_mismatch($sformatf("green_value: expected %0d, got %0d",
                                              green_want, green_value));
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        req_valid   <= 1'b0;
        command     <= CMD_WRITE;
        delta_time  <= '0;
        flavor_a    <= '0;
        flavor_b    <= '0;
        site_a      <= '0;
        site_b      <= '0;
        time_index  <= '0;
        entry_value <= '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_window_reg();
        test_directed();
        test_random_traffic(300, 0, 0, ZERO_WINDOW_RESET);
        test_random_traffic(300, 72, 0, '0);
        test_random_traffic(300, 0, 72, TIME_BITS'($urandom_range(4 << LO_BITS)));
        test_random_traffic(90, 9, 9, ZERO_WINDOW_MAX);
        test_random_traffic(210, 9, 9,
                            TIME_BITS'($urandom_range(DT_LIMIT) >> $urandom_range(TIME_BITS - 1)));
        test_backpressure();

        wait_idle();
        if (green_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", green_due.size()));
        end
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
